### hw/rtl/cdeq_pkg.sv
// ----------------------------------------------------------------------------
// cdeq_pkg
// Shared types and constants for the double-ended queue: command codes,
// status codes, cell operations and parameter defaults.
// ----------------------------------------------------------------------------
package cdeq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Command codes carried on req_command.
   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_REAR  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_REAR   = 3'd3,
      CMD_PEEK       = 3'd4
   } command_type;

   // Status codes carried on rsp_status.
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Operation broadcast to every cell of the storage row.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_BACK,
      CELL_SHIFT_FWD,
      CELL_APPEND,
      CELL_TRIM
   } cell_op_type;

endpackage

### hw/rtl/cdeq_cell.sv
// ----------------------------------------------------------------------------
// cdeq_cell
// One storage cell of the queue row. Entries are packed toward cell zero,
// which always holds the front entry.
// ----------------------------------------------------------------------------
module cdeq_cell #(
   parameter int DATA_WIDTH = cdeq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cdeq_pkg::cell_op_type   cell_op,
   input  logic [DATA_WIDTH-1:0]   push_value,
   input  logic [DATA_WIDTH-1:0]   up_data,
   input  logic                    up_valid,
   input  logic [DATA_WIDTH-1:0]   down_data,
   input  logic                    down_valid,
   output logic [DATA_WIDTH-1:0]   data,
   output logic                    valid,
   output logic [DATA_WIDTH-1:0]   last_data
);
   import cdeq_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  valid_ff;
   logic                  valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (cell_op)
         CELL_SHIFT_BACK: begin
            data_in  = up_data;
            valid_in = up_valid;
         end
         CELL_SHIFT_FWD: begin
            data_in  = down_data;
            valid_in = down_valid;
         end
         CELL_APPEND: begin
            // The first free cell behind the last occupied one takes the word.
            if (!valid_ff && up_valid) begin
               data_in  = push_value;
               valid_in = 1'b1;
            end
         end
         CELL_TRIM: begin
            if (valid_ff && !down_valid) begin
               valid_in = 1'b0;
            end
         end
         default: begin
            data_in  = data_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign valid     = valid_ff;
   assign last_data = (valid_ff && !down_valid) ? data_ff : '0;

endmodule

### hw/rtl/cdeq_or_tree.sv
// ----------------------------------------------------------------------------
// cdeq_or_tree
// Registered OR reduction that collects the single nonzero-tagged rear word
// from the cell row. Each tree level and the leaf row are registered.
// ----------------------------------------------------------------------------
module cdeq_or_tree #(
   parameter int DATA_WIDTH = cdeq_pkg::DATA_WIDTH_DEFAULT,
   parameter int LEAVES     = cdeq_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic [DATA_WIDTH-1:0] leaf_data [LEAVES],
   output logic [DATA_WIDTH-1:0] root
);
   localparam int LEVELS   = $clog2(LEAVES);
   localparam int LEAF_POW = 2 ** LEVELS;
   localparam int NODES    = 2 * LEAF_POW - 1;

   logic [DATA_WIDTH-1:0] node_ff [NODES];

   always_ff @(posedge clock) begin
      for (int n = 0; n < LEAF_POW - 1; n++) begin
         node_ff[n] <= node_ff[2*n+1] | node_ff[2*n+2];
      end
      for (int j = 0; j < LEAVES; j++) begin
         node_ff[LEAF_POW-1+j] <= leaf_data[j];
      end
      for (int j = LEAVES; j < LEAF_POW; j++) begin
         node_ff[LEAF_POW-1+j] <= '0;
      end
   end

   assign root = node_ff[0];

endmodule

### hw/rtl/circular_double_ended_queue.sv
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// Fixed-depth double-ended queue built as a row of storage cells with the
// front entry always in cell zero.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and exactly one result
// comes back on the rsp_ ports, marked by a single-cycle rsp_strobe that the
// receiver must take as it goes by. For most commands the cell row updates at
// the accept edge and the result is registered in the next cycle. A rear pop
// that leaves entries behind waits in a scan state, because the new rear word
// is gathered from the row through a registered OR tree with a register at
// each level and at the leaves. The result may be on the ports in the same
// cycle that the next item is accepted.
// ----------------------------------------------------------------------------
module circular_double_ended_queue #(
   parameter int DEPTH      = cdeq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cdeq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_command,
   input  logic signed [DATA_WIDTH-1:0]  req_value,
   output logic                          rsp_strobe,
   output logic signed [DATA_WIDTH-1:0]  rsp_popped_value,
   output logic [1:0]                    rsp_status,
   output logic signed [DATA_WIDTH-1:0]  rsp_front_value,
   output logic signed [DATA_WIDTH-1:0]  rsp_rear_value,
   output logic [$clog2(DEPTH+1)-1:0]    rsp_entry_count
);
   import cdeq_pkg::*;

   localparam int CW     = $clog2(DEPTH + 1);
   localparam int LEVELS = $clog2(DEPTH);
   localparam int WW     = $clog2(LEVELS + 2);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SETTLE,
      S_SCAN
   } state_type;

   state_type             state_ff;
   logic [CW-1:0]         count_ff;
   logic [WW-1:0]         wait_ff;
   logic [DATA_WIDTH-1:0] rear_ff;
   logic [DATA_WIDTH-1:0] popped_ff;
   status_type            status_ff;

   logic                  rsp_strobe_ff;
   logic [DATA_WIDTH-1:0] rsp_popped_ff;
   status_type            rsp_status_ff;
   logic [DATA_WIDTH-1:0] rsp_front_ff;
   logic [DATA_WIDTH-1:0] rsp_rear_ff;
   logic [CW-1:0]         rsp_count_ff;

   logic                  accept;
   logic                  is_empty;
   logic                  is_full;
   cell_op_type           cell_op;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]      cell_valid;
   logic [DATA_WIDTH-1:0] leaf_data [DEPTH];
   logic [DATA_WIDTH-1:0] tree_root;
   logic [DATA_WIDTH-1:0] front_sel;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(DEPTH));

   // The front word after the operation sits in cell zero; an empty queue
   // reports all ones at both ends.
   assign front_sel = is_empty ? '1 : cell_data[0];

   // Every cell gets the same operation; refused commands leave the row alone.
   always_comb begin
      cell_op = CELL_HOLD;
      if (accept) begin
         case (req_command)
            CMD_PUSH_FRONT: if (!is_full)  cell_op = CELL_SHIFT_BACK;
            CMD_PUSH_REAR:  if (!is_full)  cell_op = CELL_APPEND;
            CMD_POP_FRONT:  if (!is_empty) cell_op = CELL_SHIFT_FWD;
            CMD_POP_REAR:   if (!is_empty) cell_op = CELL_TRIM;
            default:        cell_op = CELL_HOLD;
         endcase
      end
   end

   // The row of cells. Cell zero sees the pushed word as its upstream
   // neighbor, and the last cell sees an empty neighbor downstream.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] up_data;
      logic                  up_valid;
      logic [DATA_WIDTH-1:0] down_data;
      logic                  down_valid;

      if (i == 0) begin : g_head
         assign up_data  = req_value;
         assign up_valid = 1'b1;
      end else begin : g_body
         assign up_data  = cell_data[i-1];
         assign up_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign down_data  = '0;
         assign down_valid = 1'b0;
      end else begin : g_mid
         assign down_data  = cell_data[i+1];
         assign down_valid = cell_valid[i+1];
      end

      cdeq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_op    (cell_op),
         .push_value (req_value),
         .up_data    (up_data),
         .up_valid   (up_valid),
         .down_data  (down_data),
         .down_valid (down_valid),
         .data       (cell_data[i]),
         .valid      (cell_valid[i]),
         .last_data  (leaf_data[i])
      );
   end

   // Only the last occupied cell presents its word, so the OR of all leaves
   // is the rear word of the row.
   cdeq_or_tree #(
      .DATA_WIDTH (DATA_WIDTH),
      .LEAVES     (DEPTH)
   ) u_rear_tree (
      .clock     (clock),
      .leaf_data (leaf_data),
      .root      (tree_root)
   );

   // Control, bookkeeping and the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         wait_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  popped_ff <= '1;
                  status_ff <= ST_DONE;
                  state_ff  <= S_SETTLE;
                  case (req_command)
                     CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                        if (is_full) begin
                           status_ff <= ST_FULL;
                        end else begin
                           count_ff <= count_ff + CW'(1);
                           // A front push changes the rear only on an empty queue.
                           if (req_command == CMD_PUSH_REAR || is_empty) begin
                              rear_ff <= req_value;
                           end
                        end
                     end
                     CMD_POP_FRONT: begin
                        if (is_empty) begin
                           status_ff <= ST_EMPTY;
                        end else begin
                           popped_ff <= cell_data[0];
                           count_ff  <= count_ff - CW'(1);
                        end
                     end
                     CMD_POP_REAR: begin
                        if (is_empty) begin
                           status_ff <= ST_EMPTY;
                        end else begin
                           popped_ff <= rear_ff;
                           count_ff  <= count_ff - CW'(1);
                           // The new rear word must be gathered from the row.
                           if (count_ff != CW'(1)) begin
                              state_ff <= S_SCAN;
                              wait_ff  <= WW'(LEVELS + 1);
                           end
                        end
                     end
                     CMD_PEEK: begin
                        if (is_empty) begin
                           status_ff <= ST_EMPTY;
                        end
                     end
                     default: begin
                        status_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            S_SETTLE: begin
               rsp_strobe_ff <= 1'b1;
               rsp_popped_ff <= popped_ff;
               rsp_status_ff <= status_ff;
               rsp_front_ff  <= front_sel;
               rsp_rear_ff   <= is_empty ? '1 : rear_ff;
               rsp_count_ff  <= count_ff;
               state_ff      <= S_IDLE;
            end
            S_SCAN: begin
               if (wait_ff == '0) begin
                  // The queue is known to hold entries here.
                  rear_ff       <= tree_root;
                  rsp_strobe_ff <= 1'b1;
                  rsp_popped_ff <= popped_ff;
                  rsp_status_ff <= status_ff;
                  rsp_front_ff  <= front_sel;
                  rsp_rear_ff   <= tree_root;
                  rsp_count_ff  <= count_ff;
                  state_ff      <= S_IDLE;
               end else begin
                  wait_ff <= wait_ff - WW'(1);
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_front_value  = rsp_front_ff;
   assign rsp_rear_value   = rsp_rear_ff;
   assign rsp_entry_count  = rsp_count_ff;

   // The occupied cells always match the entry count.
   a_row_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("cell row occupancy differs from entry count");

   // The count never exceeds the depth.
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // An accepted item makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not raise busy");

   // A result only follows a cycle in which an item was being worked on.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_strobe) |-> $past(busy))
      else $error("result strobe without work in progress");

   // A refused push is reported only on a full queue.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> (rsp_entry_count == CW'(DEPTH)))
      else $error("full status with free entries");

endmodule
